// ----- design/vertex_label_pair_sorter_unit_macros.svh -----
// Assertion macros for the vertex label pair sorter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef VERTEX_LABEL_PAIR_SORTER_UNIT_MACROS_SVH
`define VERTEX_LABEL_PAIR_SORTER_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define VLPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define VLPS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/vlps_pkg.sv -----
// Shared constants and types of the vertex label pair sorter.
// No dependencies.
package vlps_pkg;

  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned VertexBitsDef = 32;
  localparam int unsigned LabelBits     = 8;

  // Flip the label sign bit so that an unsigned compare orders signed labels.
  localparam logic [LabelBits-1:0] LabelSignFlip = 8'h80;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- design/vlps_if.sv -----
// Request channels of the vertex label pair sorter: incoming pairs and sorted pairs.
// Depends on vlps_pkg.
interface vlps_in_if #(
  parameter int unsigned VertexBits = vlps_pkg::VertexBitsDef
);
  logic                                  valid;
  logic                                  ready;
  logic [VertexBits-1:0]                 vertex;
  logic signed [vlps_pkg::LabelBits-1:0] label;
  logic                                  last;

  modport source (output valid, vertex, label, last, input ready);
  modport sink   (input valid, vertex, label, last, output ready);
endinterface

interface vlps_out_if #(
  parameter int unsigned VertexBits = vlps_pkg::VertexBitsDef
);
  logic                                  valid;
  logic                                  ready;
  logic [VertexBits-1:0]                 sorted_vertex;
  logic signed [vlps_pkg::LabelBits-1:0] sorted_label;
  logic                                  end_of_batch;
  logic                                  overflow;

  modport source (output valid, sorted_vertex, sorted_label, end_of_batch, overflow,
                  input ready);
  modport sink   (input valid, sorted_vertex, sorted_label, end_of_batch, overflow,
                  output ready);
endinterface

// ----- design/vlps_cell.sv -----
// One cell of the insertion sort chain: holds one pair and its valid bit.
// Depends on vlps_pkg.
module vlps_cell #(
  parameter int unsigned VertexBits = vlps_pkg::VertexBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  vlps_pkg::cell_ctrl_t                  ctrl_i,
  input  logic [VertexBits-1:0]                 new_vertex_i,
  input  logic signed [vlps_pkg::LabelBits-1:0] new_label_i,
  input  logic                                  left_valid_i,
  input  logic                                  left_take_i,
  input  logic [VertexBits-1:0]                 left_vertex_i,
  input  logic signed [vlps_pkg::LabelBits-1:0] left_label_i,
  input  logic                                  right_valid_i,
  input  logic [VertexBits-1:0]                 right_vertex_i,
  input  logic signed [vlps_pkg::LabelBits-1:0] right_label_i,
  output logic                                  valid_o,
  output logic                                  take_o,
  output logic [VertexBits-1:0]                 vertex_o,
  output logic signed [vlps_pkg::LabelBits-1:0] label_o
);

  localparam int unsigned KeyBits = VertexBits + vlps_pkg::LabelBits;

  logic                                  valid_q, valid_d;
  logic [VertexBits-1:0]                 vertex_q, vertex_d;
  logic signed [vlps_pkg::LabelBits-1:0] label_q, label_d;
  logic [KeyBits-1:0]                    new_key, own_key;
  logic                                  new_less;
  logic                                  take;

  // Compare keys lexicographically: vertex unsigned, then label signed.
  assign new_key  = {new_vertex_i, new_label_i ^ vlps_pkg::LabelSignFlip};
  assign own_key  = {vertex_q, label_q ^ vlps_pkg::LabelSignFlip};
  assign new_less = new_key < own_key;

  // Take a pair when the new one sorts before ours, or we are the first empty cell.
  assign take = ctrl_i.insert && (valid_q ? new_less : left_valid_i);

  // Shift left while draining; otherwise take the displaced left pair or the new one.
  always_comb begin
    valid_d  = valid_q;
    vertex_d = vertex_q;
    label_d  = label_q;
    if (ctrl_i.shift) begin
      valid_d  = right_valid_i;
      vertex_d = right_vertex_i;
      label_d  = right_label_i;
    end else if (take) begin
      valid_d = 1'b1;
      if (left_take_i) begin
        vertex_d = left_vertex_i;
        label_d  = left_label_i;
      end else begin
        vertex_d = new_vertex_i;
        label_d  = new_label_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vertex_q <= vertex_d;
    label_q  <= label_d;
  end

  assign valid_o  = valid_q;
  assign take_o   = take;
  assign vertex_o = vertex_q;
  assign label_o  = label_q;

endmodule

// ----- design/vertex_label_pair_sorter_unit.sv -----
// Vertex label pair sorter: chain of MAX_ENTRIES insertion cells plus an output register.
// A batch of n stored pairs is taken at one pair per cycle while filling; after the last pair
// is accepted the drain flag is set, then the sorted pairs leave through the output register,
// one pair per cycle while the sorted side is ready, with the input stalled during that drain.
// Reset clears all cell valid bits, the drop flag and the output valid bit; no clearing pass.
// Depends on vlps_pkg, vlps_if, vlps_cell and the assertion macro header.
`include "vertex_label_pair_sorter_unit_macros.svh"

module vertex_label_pair_sorter_unit #(
  parameter int unsigned MAX_ENTRIES = vlps_pkg::MaxEntriesDef,
  parameter int unsigned VERTEX_BITS = vlps_pkg::VertexBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vlps_in_if.sink           pair_i,
  vlps_out_if.source        sorted_o
);

  logic                                  cell_valid  [MAX_ENTRIES];
  logic                                  cell_take   [MAX_ENTRIES];
  logic [VERTEX_BITS-1:0]                cell_vertex [MAX_ENTRIES];
  logic signed [vlps_pkg::LabelBits-1:0] cell_label  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]                valid_vec;

  vlps_pkg::cell_ctrl_t                  ctrl;
  logic                                  in_fire;
  logic                                  full;
  logic                                  advance;
  logic                                  batch_done;

  logic                                  drain_q, drain_d;
  logic                                  dropped_q, dropped_d;
  logic                                  out_valid_q, out_valid_d;
  logic [VERTEX_BITS-1:0]                out_vertex_q;
  logic signed [vlps_pkg::LabelBits-1:0] out_label_q;
  logic                                  out_eob_q;
  logic                                  out_ovf_q;

  // Accept requests only while filling; a full chain drops the request.
  assign pair_i.ready = !drain_q;
  assign in_fire      = pair_i.valid && pair_i.ready;
  assign full         = cell_valid[MAX_ENTRIES-1];

  // Move the head pair out whenever the output slot is free or being taken.
  assign advance     = !out_valid_q || sorted_o.ready;
  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = drain_q && advance;
  assign batch_done  = ctrl.shift && !cell_valid[1];

  // Build the cell chain; cell 0 sees an always-valid left edge, the tail an empty right.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                                  left_valid;
    logic                                  left_take;
    logic [VERTEX_BITS-1:0]                left_vertex;
    logic signed [vlps_pkg::LabelBits-1:0] left_label;
    logic                                  right_valid;
    logic [VERTEX_BITS-1:0]                right_vertex;
    logic signed [vlps_pkg::LabelBits-1:0] right_label;

    if (i == 0) begin : g_head
      assign left_valid  = 1'b1;
      assign left_take   = 1'b0;
      assign left_vertex = pair_i.vertex;
      assign left_label  = pair_i.label;
    end else begin : g_body
      assign left_valid  = cell_valid[i-1];
      assign left_take   = cell_take[i-1];
      assign left_vertex = cell_vertex[i-1];
      assign left_label  = cell_label[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_valid  = 1'b0;
      assign right_vertex = pair_i.vertex;
      assign right_label  = pair_i.label;
    end else begin : g_next
      assign right_valid  = cell_valid[i+1];
      assign right_vertex = cell_vertex[i+1];
      assign right_label  = cell_label[i+1];
    end

    vlps_cell #(
      .VertexBits (VERTEX_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_vertex_i   (pair_i.vertex),
      .new_label_i    (pair_i.label),
      .left_valid_i   (left_valid),
      .left_take_i    (left_take),
      .left_vertex_i  (left_vertex),
      .left_label_i   (left_label),
      .right_valid_i  (right_valid),
      .right_vertex_i (right_vertex),
      .right_label_i  (right_label),
      .valid_o        (cell_valid[i]),
      .take_o         (cell_take[i]),
      .vertex_o       (cell_vertex[i]),
      .label_o        (cell_label[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  // Enter drain on the batch's last request; leave once the final pair moves out.
  always_comb begin
    drain_d   = drain_q;
    dropped_d = dropped_q;
    if (in_fire && full) begin
      dropped_d = 1'b1;
    end
    if (in_fire && pair_i.last) begin
      drain_d = 1'b1;
    end
    if (batch_done) begin
      drain_d   = 1'b0;
      dropped_d = 1'b0;
    end
  end

  // Hold the output pair until taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.shift) begin
      out_valid_d = 1'b1;
    end else if (sorted_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      drain_q     <= drain_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.shift) begin
      out_vertex_q <= cell_vertex[0];
      out_label_q  <= cell_label[0];
      out_eob_q    <= !cell_valid[1];
      out_ovf_q    <= dropped_q;
    end
  end

  assign sorted_o.valid         = out_valid_q;
  assign sorted_o.sorted_vertex = out_vertex_q;
  assign sorted_o.sorted_label  = out_label_q;
  assign sorted_o.end_of_batch  = out_eob_q;
  assign sorted_o.overflow      = out_ovf_q;

  `VLPS_ASSERT(a_valid_contiguous, ((valid_vec >> 1) & ~valid_vec) == '0, "cell valid bits have a gap")
  `VLPS_ASSERT(a_drain_has_head, drain_q |-> cell_valid[0], "draining with an empty head cell")
  `VLPS_ASSERT(a_last_starts_drain, in_fire && pair_i.last |=> drain_q, "last request did not start drain")
  `VLPS_ASSERT(a_drain_fills_output, drain_q && !out_valid_q |=> out_valid_q, "drain stalled with a free output")
  `VLPS_ASSERT(a_done_clears_drop, batch_done |=> !dropped_q && !drain_q, "batch end left drain state")

endmodule

// ----- sim/vlps_sort_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard of the vertex label pair sorter: watches the pair and sorted request
// channels, predicts the sorted stream and compares it. Depends on vlps_pkg and vlps_if.
module vlps_sort_checker #(
  parameter int unsigned MaxEntries = vlps_pkg::MaxEntriesDef,
  parameter int unsigned VertexBits = vlps_pkg::VertexBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic final_check_i,
  vlps_in_if   pair_mon,
  vlps_out_if  sorted_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    logic [VertexBits-1:0]          vertex;
    logic [vlps_pkg::LabelBits-1:0] label;
  } pair_t;

  typedef struct packed {
    pair_t pair;
    logic  end_of_batch;
    logic  overflow;
  } sorted_pair_t;

  pair_t        batch_pairs[$];
  logic         batch_dropped = 1'b0;
  sorted_pair_t sorted_expect_q[$];
  int           fail_count = 0;
  int           pending = 0;
  int           checked = 0;
  logic         final_done = 1'b0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;

  // Count a failure, print only the first few.
  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk_i) begin : track
    pair_t        key;
    sorted_pair_t want;
    sorted_pair_t got;
    int           idx;
    if (rst_ni) begin
      // Compare a sorted request with the oldest expectation
      if (sorted_mon.valid && sorted_mon.ready) begin
        got.pair.vertex  = sorted_mon.sorted_vertex;
        got.pair.label   = sorted_mon.sorted_label;
        got.end_of_batch = sorted_mon.end_of_batch;
        got.overflow     = sorted_mon.overflow;
        if (sorted_expect_q.size() == 0) begin
          report_failure($sformatf("unexpected sorted pair vertex=%h label=%0d eob=%b ovf=%b",
                                   got.pair.vertex, $signed(got.pair.label),
                                   got.end_of_batch, got.overflow));
        end else begin
          want = sorted_expect_q.pop_front();
          checked++;
          if (got.pair.vertex !== want.pair.vertex || got.pair.label !== want.pair.label ||
              got.end_of_batch !== want.end_of_batch || got.overflow !== want.overflow) begin
            report_failure($sformatf(
              "result %0d expected vertex=%h label=%0d eob=%b ovf=%b, got vertex=%h label=%0d eob=%b ovf=%b",
              checked, want.pair.vertex, $signed(want.pair.label), want.end_of_batch,
              want.overflow, got.pair.vertex, $signed(got.pair.label), got.end_of_batch,
              got.overflow));
          end
        end
      end

      // Store an incoming pair, or drop it when the store is full
      if (pair_mon.valid && pair_mon.ready) begin
        if (batch_pairs.size() < MaxEntries) begin
          key.vertex = pair_mon.vertex;
          key.label  = pair_mon.label;
          batch_pairs.push_back(key);
        end else begin
          batch_dropped = 1'b1;
        end

        if (pair_mon.last) begin
          // Order by vertex (unsigned), then by label (signed)
          for (int j = 1; j < batch_pairs.size(); j++) begin
            key = batch_pairs[j];
            idx = j;
            while (idx > 0 && (key.vertex < batch_pairs[idx-1].vertex ||
                   (key.vertex == batch_pairs[idx-1].vertex &&
                    $signed(key.label) < $signed(batch_pairs[idx-1].label)))) begin
              batch_pairs[idx] = batch_pairs[idx-1];
              idx--;
            end
            batch_pairs[idx] = key;
          end
          // Queue the whole sorted batch and start a new one
          foreach (batch_pairs[k]) begin
            want.pair         = batch_pairs[k];
            want.end_of_batch = (k == batch_pairs.size() - 1);
            want.overflow     = batch_dropped;
            sorted_expect_q.push_back(want);
          end
          batch_pairs.delete();
          batch_dropped = 1'b0;
        end
      end

      // Flag results that never came
      if (final_check_i && !final_done) begin
        final_done = 1'b1;
        if (sorted_expect_q.size() != 0) begin
          report_failure($sformatf("%0d sorted pairs never arrived", sorted_expect_q.size()));
        end
      end

      pending = sorted_expect_q.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top of the vertex label pair sorter: clock, reset, pair stimulus and verdict.
// Depends on vlps_pkg, vlps_if, vertex_label_pair_sorter_unit and vlps_sort_checker.
module tb_top;

  localparam int unsigned MaxEntries = vlps_pkg::MaxEntriesDef;
  localparam int unsigned VertexBits = vlps_pkg::VertexBitsDef;
  localparam int StallLimit     = 2000;
  localparam int LongHoldCycles = 300;
  localparam int TailCycles     = 10;
  localparam int CalmItems      = 370;
  localparam int TargetItems    = 430;

  typedef enum int {KEY_WIDE, KEY_CLUSTERED, KEY_CORNER} key_mode_e;

  logic clk;
  logic rst_n         = 1'b0;
  logic final_check   = 1'b0;
  logic sink_hold_req = 1'b0;
  logic calm          = 1'b0;
  int   fail_count;
  int   pending;
  int   checked;
  int   pairs_sent       = 0;
  int   batches_sent     = 0;
  int   overflow_batches = 0;

  vlps_in_if  #(.VertexBits(VertexBits)) pair_if ();
  vlps_out_if #(.VertexBits(VertexBits)) sorted_if ();

  vertex_label_pair_sorter_unit #(
    .MAX_ENTRIES(MaxEntries),
    .VERTEX_BITS(VertexBits)
  ) u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pair_i  (pair_if),
    .sorted_o(sorted_if)
  );

  vlps_sort_checker #(
    .MaxEntries(MaxEntries),
    .VertexBits(VertexBits)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .final_check_i(final_check),
    .pair_mon     (pair_if),
    .sorted_mon   (sorted_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick a vertex: full range, a tight cluster for ties, or the corners
  function automatic logic [VertexBits-1:0] pick_vertex(key_mode_e mode);
    logic [VertexBits-1:0] v;
    v = VertexBits'({$urandom(), $urandom()});
    case (mode)
      KEY_CLUSTERED: v = VertexBits'($urandom_range(0, 7));
      KEY_CORNER: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, {(VertexBits-1){1'b0}}};
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // Pick a label, with the sign boundaries often
  function automatic logic [vlps_pkg::LabelBits-1:0] pick_label();
    logic [vlps_pkg::LabelBits-1:0] l;
    case ($urandom_range(0, 7))
      0: l = 8'h80;
      1: l = 8'h7f;
      2: l = 8'h00;
      3: l = 8'hff;
      default: l = vlps_pkg::LabelBits'($urandom());
    endcase
    return l;
  endfunction

  // Offer one pair request, idle before it now and then; returns at a falling edge
  task automatic send_pair(input logic [VertexBits-1:0] vertex,
                           input logic [vlps_pkg::LabelBits-1:0] label, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      pair_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    pair_if.valid  = 1'b1;
    pair_if.vertex = vertex;
    pair_if.label  = label;
    pair_if.last   = last;
    do @(posedge clk); while (!pair_if.ready);
    @(negedge clk);
    pairs_sent++;
    if (last) begin
      batches_sent++;
    end
  endtask

  task automatic send_batch(input int count);
    key_mode_e mode;
    mode = key_mode_e'($urandom_range(0, 2));
    for (int k = 0; k < count; k++) begin
      send_pair(pick_vertex(mode), pick_label(), k == count - 1);
    end
    if (count > MaxEntries) begin
      overflow_batches++;
    end
  endtask

  // Hold the sender until every sorted pair has come back
  task automatic pause_until_drained();
    pair_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Sorted side: random holds, one long hold on request, none near the end
  initial begin : sink_side
    sorted_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sorted_if.ready = 1'b0;
        repeat (LongHoldCycles - 1) @(negedge clk);
        sink_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sorted_if.ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        sorted_if.ready = 1'b1;
      end
    end
  end

  // End the run when no request moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((pair_if.valid && pair_if.ready) || (sorted_if.valid && sorted_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    pair_if.valid  = 1'b0;
    pair_if.vertex = '0;
    pair_if.label  = '0;
    pair_if.last   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes, both keys, duplicates
    send_pair('1, 8'h7f, 1'b0);
    send_pair('0, 8'h80, 1'b0);
    send_pair('0, 8'h7f, 1'b0);
    send_pair('0, 8'hff, 1'b0);
    send_pair('0, 8'h00, 1'b0);
    send_pair('1, 8'h80, 1'b0);
    send_pair('0, 8'h80, 1'b0);
    send_pair({1'b1, {(VertexBits-1){1'b0}}}, 8'h01, 1'b1);
    // Single-pair batch
    send_pair(VertexBits'(32'h1234_5678), 8'hfb, 1'b1);
    // Equal vertices, labels on both sides of zero, exact duplicates
    send_pair(VertexBits'(7), 8'h03, 1'b0);
    send_pair(VertexBits'(7), 8'h03, 1'b0);
    send_pair(VertexBits'(7), 8'hfd, 1'b0);
    send_pair(VertexBits'(6), 8'h03, 1'b0);
    send_pair(VertexBits'(7), 8'h80, 1'b1);
    // Alternating bit patterns
    send_pair({(VertexBits/2){2'b10}}, 8'h55, 1'b0);
    send_pair({(VertexBits/2){2'b01}}, 8'haa, 1'b1);
    pause_until_drained();

    // Stall the sorted side while pairs keep coming, so the input backs up
    sink_hold_req = 1'b1;
    send_batch(20);
    send_batch(30);

    // Store limits: exactly full, last pair dropped, several dropped
    send_batch(MaxEntries);
    send_batch(MaxEntries + 1);
    send_batch(MaxEntries + 6);
    pause_until_drained();

    // Random batches, mostly small
    while (pairs_sent < CalmItems) begin
      if ($urandom_range(0, 19) == 0) begin
        send_batch($urandom_range(MaxEntries - 4, MaxEntries + 8));
      end else begin
        send_batch($urandom_range(1, 16));
      end
    end
    calm = 1'b1;
    while (pairs_sent < TargetItems) begin
      send_batch($urandom_range(1, 16));
    end
    pair_if.valid = 1'b0;

    // Drain and settle
    while (pending != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    final_check = 1'b1;
    @(negedge clk);

    $display("Sent %0d pairs in %0d batches (%0d over capacity); checked %0d sorted pairs.",
             pairs_sent, batches_sent, overflow_batches, checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
